>>> sv/contiguous_page_bitmap_allocator_macros.svh
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator: assertion macros
// Shared property forms for the allocator's checks. Clock and reset are
// taken from the ports of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define CPBA_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPBA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cpba_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator: package
// Field widths, register indexes, reset values, codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package cpba_pkg;

   // map size
   localparam int MAP_PAGES_DEFAULT = 512;

   // field widths
   localparam int MODE_W      = 1;
   localparam int LEN_W       = 32;
   localparam int ADDR_W      = 39;
   localparam int STATUS_W    = 2;
   localparam int START_W     = 9;
   localparam int COUNT_W     = 21;
   localparam int LG_W        = 5;
   localparam int MAP_BYTES_W = 7;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_SIZE_LOG2   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_BYTES_IN_USE = 1'd1;

   localparam logic [LG_W-1:0]        PAGE_SIZE_LOG2_RESET   = 5'd21;
   localparam logic [MAP_BYTES_W-1:0] MAP_BYTES_IN_USE_RESET = 7'd64;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_MAP = 2'd2;

   // control for the row unit
   typedef struct packed {
      logic scan_en;     // 1: run search, 0: range fill
      logic fill_value;  // value written into the page range
   } row_ctrl_type;

endpackage

`default_nettype wire

>>> sv/contiguous_page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator
// First-fit allocation and release of contiguous runs in a page-used bitmap.
// ----------------------------------------------------------------------------
// The map holds one used bit per page, stored as bytes in a single-port-read,
// single-port-write memory, and every bit is handled by one row unit that
// works a byte per cycle. After reset the block clears the map and takes no
// request meanwhile; configuration writes are taken at any time. A request
// then passes through the load, setup, scan, issue, update and finish steps
// before its result is registered and the next request is taken: the scan
// (allocate only) reads bytes up to the one holding the end of the first
// free run, or the whole searched range when nothing fits, and the update
// sets or clears the bytes holding the run. A request that touches no run
// because nothing fits, the searched range is empty or the free start is
// off the map skips the issue step. The scan is bounded by
// min(8 * map_bytes_in_use, MAP_PAGES) pages. The result sits in an output
// register, so a new request is taken while an earlier result is still
// stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_page_bitmap_allocator #(
   parameter int MAP_PAGES = cpba_pkg::MAP_PAGES_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,

   // configuration
   input  wire logic                             csr_wr_en,
   input  wire logic [cpba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cpba_pkg::CSR_DATA_W-1:0]  csr_wdata,

   // requests
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cpba_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [cpba_pkg::LEN_W-1:0]    req_length_bytes,
   input  wire logic [cpba_pkg::ADDR_W-1:0]   req_address,

   // results
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [cpba_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cpba_pkg::START_W-1:0]       rsp_first_page,
   output logic [cpba_pkg::ADDR_W-1:0]        rsp_virt_address,
   output logic [cpba_pkg::COUNT_W-1:0]       rsp_page_count
);

   // sizes
   localparam int ROWS = (MAP_PAGES + 7) / 8;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;    // row address
   localparam int XW   = RW + 4;                            // page index, counts
   localparam int IDXW = $clog2(MAP_PAGES);                 // page below MAP_PAGES
   localparam int LW   = (XW > 10) ? XW : 10;               // limit arithmetic
   localparam int LEN_W  = cpba_pkg::LEN_W;
   localparam int ADDR_W = cpba_pkg::ADDR_W;

   // sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;  // clearing pass after reset
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;  // page count and free index
   localparam logic [2:0] ST_SETUP  = 3'd3;  // limits, first read
   localparam logic [2:0] ST_SCAN   = 3'd4;  // first-fit, a byte per cycle
   localparam logic [2:0] ST_ISSUE  = 3'd5;  // read first byte of the run
   localparam logic [2:0] ST_RMW    = 3'd6;  // set or clear, a byte per cycle
   localparam logic [2:0] ST_FINISH = 3'd7;  // load result register

   // configuration registers
   logic [cpba_pkg::LG_W-1:0]        lg_ff;
   logic [cpba_pkg::MAP_BYTES_W-1:0] map_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_ff        <= cpba_pkg::PAGE_SIZE_LOG2_RESET;
         map_bytes_ff <= cpba_pkg::MAP_BYTES_IN_USE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cpba_pkg::CSR_PAGE_SIZE_LOG2: begin
               lg_ff <= csr_wdata[cpba_pkg::LG_W-1:0];
            end
            cpba_pkg::CSR_MAP_BYTES_IN_USE: begin
               map_bytes_ff <= csr_wdata[cpba_pkg::MAP_BYTES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer and work registers
   logic [2:0]                       state_ff,  state_in;
   logic [RW-1:0]                    row_ff,    row_in;
   logic [cpba_pkg::MODE_W-1:0]      mode_ff,   mode_in;
   logic [LEN_W-1:0]                 len_ff,    len_in;
   logic [ADDR_W-1:0]                addr_ff,   addr_in;
   logic [LEN_W-1:0]                 count_ff,  count_in;
   logic [ADDR_W-1:0]                idx_ff,    idx_in;
   logic [XW-1:0]                    cnt_sat_ff, cnt_sat_in;  // count, capped
   logic [XW-1:0]                    want_ff,   want_in;
   logic [XW-1:0]                    limit_ff,  limit_in;
   logic [XW-1:0]                    run_ff,    run_in;
   logic [XW-1:0]                    runst_ff,  runst_in;
   logic [XW-1:0]                    lo_ff,     lo_in;
   logic [XW-1:0]                    end_ff,    end_in;
   logic [IDXW-1:0]                  start_ff,  start_in;
   logic [cpba_pkg::STATUS_W-1:0]    status_ff, status_in;

   // result register
   logic                             rsp_valid_ff,   rsp_valid_in;
   logic [cpba_pkg::STATUS_W-1:0]    rsp_status_ff,  rsp_status_in;
   logic [cpba_pkg::START_W-1:0]     rsp_start_ff,   rsp_start_in;
   logic [ADDR_W-1:0]                rsp_va_ff,      rsp_va_in;
   logic [cpba_pkg::COUNT_W-1:0]     rsp_count_ff,   rsp_count_in;

   // memory port
   logic          wr_en;
   logic [RW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [RW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // row unit
   cpba_pkg::row_ctrl_type ctrl;
   logic [7:0]    row_out;
   logic [XW-1:0] run_out;
   logic [XW-1:0] runst_out;
   logic          found;

   // helpers
   logic [XW-1:0] row_base;
   logic [RW:0]   row_nx;
   logic [XW-1:0] next_base;
   logic [RW-1:0] row_nx_rd;   // next row, held at the last row
   logic [LEN_W:0]  round_sum;
   logic [LW-1:0]   lim_raw;
   logic [LW-1:0]   lim_cap;
   logic [XW:0]     free_end;
   logic [ADDR_W-1:0] start_ext;

   assign row_base  = {1'b0, row_ff, 3'b000};
   assign row_nx    = (RW+1)'(row_ff) + (RW+1)'(1);
   assign next_base = {row_nx, 3'b000};
   assign row_nx_rd = (row_ff == RW'(ROWS - 1)) ? row_ff : row_nx[RW-1:0];

   // byte length rounded up to pages: (len + 2^lg - 1) >> lg
   assign round_sum = {1'b0, len_ff}
                    + (((LEN_W+1)'(1) << lg_ff) - (LEN_W+1)'(1));

   assign lim_raw  = LW'({map_bytes_ff, 3'b000});
   assign lim_cap  = (lim_raw > LW'(MAP_PAGES)) ? LW'(MAP_PAGES) : lim_raw;
   assign free_end = (XW+1)'(idx_ff[XW-1:0]) + (XW+1)'(cnt_sat_ff);

   assign start_ext = ADDR_W'(start_ff);

   assign ctrl = '{scan_en:    (state_ff == ST_SCAN),
                   fill_value: (mode_ff == cpba_pkg::MODE_ALLOC)};

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      mode_in     = mode_ff;
      len_in      = len_ff;
      addr_in     = addr_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      cnt_sat_in  = cnt_sat_ff;
      want_in     = want_ff;
      limit_in    = limit_ff;
      run_in      = run_ff;
      runst_in    = runst_ff;
      lo_in       = lo_ff;
      end_in      = end_ff;
      start_in    = start_ff;
      status_in   = status_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_va_in     = rsp_va_ff;
      rsp_count_in  = rsp_count_ff;

      wr_en   = 1'b0;
      wr_addr = row_ff;
      wr_data = row_out;
      rd_addr = row_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = 8'h00;
            if (row_ff == RW'(ROWS - 1)) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end else begin
               row_in = row_nx[RW-1:0];
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               len_in   = req_length_bytes;
               addr_in  = req_address;
               state_in = ST_LOAD;
            end
         end

         ST_LOAD: begin
            count_in  = LEN_W'(round_sum >> lg_ff);
            idx_in    = addr_ff >> lg_ff;
            status_in = cpba_pkg::STATUS_OK;
            start_in  = '0;
            state_in  = ST_SETUP;
         end

         ST_SETUP: begin
            // cap the count just above the map so it fits narrow compares
            if (count_ff > LEN_W'(MAP_PAGES)) begin
               cnt_sat_in = XW'(MAP_PAGES + 1);
            end else begin
               cnt_sat_in = XW'(count_ff);
            end
            // a zero-length allocate looks for a single free page
            want_in  = (count_ff == '0) ? XW'(1) : cnt_sat_in;
            limit_in = XW'(lim_cap);
            run_in   = '0;
            runst_in = '0;
            row_in   = '0;
            rd_addr  = '0;
            if (mode_ff == cpba_pkg::MODE_ALLOC) begin
               if (lim_cap == '0) begin
                  status_in = cpba_pkg::STATUS_NO_SPACE;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end else if (idx_ff >= ADDR_W'(MAP_PAGES)) begin
               status_in = cpba_pkg::STATUS_OUT_OF_MAP;
               state_in  = ST_FINISH;
            end else begin
               start_in = idx_ff[IDXW-1:0];
               lo_in    = idx_ff[XW-1:0];
               state_in = ST_ISSUE;
            end
         end

         ST_SCAN: begin
            rd_addr = row_nx_rd;
            if (found) begin
               start_in = runst_out[IDXW-1:0];
               lo_in    = runst_out;
               end_in   = runst_out + cnt_sat_ff;
               state_in = ST_ISSUE;
            end else if (next_base >= limit_ff) begin
               status_in = cpba_pkg::STATUS_NO_SPACE;
               state_in  = ST_FINISH;
            end else begin
               run_in   = run_out;
               runst_in = runst_out;
               row_in   = row_nx[RW-1:0];
            end
         end

         ST_ISSUE: begin
            // free runs end at the map edge; allocate runs fit by construction
            if (mode_ff == cpba_pkg::MODE_FREE) begin
               if (free_end > (XW+1)'(MAP_PAGES)) begin
                  end_in = XW'(MAP_PAGES);
               end else begin
                  end_in = free_end[XW-1:0];
               end
            end
            rd_addr = lo_ff[RW+2:3];
            row_in  = lo_ff[RW+2:3];
            if (end_in > lo_ff) begin
               state_in = ST_RMW;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_RMW: begin
            wr_en   = 1'b1;
            rd_addr = row_nx_rd;
            if (next_base >= end_ff) begin
               state_in = ST_FINISH;
            end else begin
               row_in = row_nx[RW-1:0];
            end
         end

         ST_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_start_in  = start_ext[cpba_pkg::START_W-1:0];
               rsp_va_in     = start_ext << lg_ff;
               rsp_count_in  = count_ff[cpba_pkg::COUNT_W-1:0];
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      len_ff        <= len_in;
      addr_ff       <= addr_in;
      count_ff      <= count_in;
      idx_ff        <= idx_in;
      cnt_sat_ff    <= cnt_sat_in;
      want_ff       <= want_in;
      limit_ff      <= limit_in;
      run_ff        <= run_in;
      runst_ff      <= runst_in;
      lo_ff         <= lo_in;
      end_ff        <= end_in;
      start_ff      <= start_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_va_ff     <= rsp_va_in;
      rsp_count_ff  <= rsp_count_in;
   end

   cpba_map_mem #(
      .ROWS (ROWS),
      .RW   (RW)
   ) u_map_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cpba_row_unit #(
      .XW (XW)
   ) u_row_unit (
      .ctrl      (ctrl),
      .row_data  (rd_data),
      .base      (row_base),
      .limit     (limit_ff),
      .want      (want_ff),
      .run_in    (run_ff),
      .start_in  (runst_ff),
      .lo        (lo_ff),
      .hi        (end_ff),
      .row_out   (row_out),
      .run_out   (run_out),
      .start_out (runst_out),
      .found     (found)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_first_page   = rsp_start_ff;
   assign rsp_virt_address = rsp_va_ff;
   assign rsp_page_count   = rsp_count_ff;

   // checks
`include "contiguous_page_bitmap_allocator_macros.svh"

   // an accepted beat always starts the count stage
   `CPBA_ASSERT_NEXT(a_accept_loads, (req_valid && !req_stall), (state_ff == ST_LOAD), "accepted beat did not start work")

   // the result register loads when free and the block returns to idle
   `CPBA_ASSERT_NEXT(a_finish_delivers, ((state_ff == ST_FINISH) && !(rsp_valid_ff && rsp_stall)), (rsp_valid_ff && (state_ff == ST_IDLE)), "result not loaded on finish")

   // the map is only written by the clearing pass or a run update
   `CPBA_ASSERT_NOW(a_write_state, wr_en, ((state_ff == ST_CLEAR) || (state_ff == ST_RMW)), "bitmap written outside clear or update")

   // a run update never touches a byte wholly past the run end
   `CPBA_ASSERT_NOW(a_rmw_in_run, (state_ff == ST_RMW), (row_base < end_ff), "run update past run end")

endmodule

`default_nettype wire

>>> sv/cpba_map_mem.sv
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator: bitmap store
// One byte of page-used bits per row; one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpba_map_mem #(
   parameter int ROWS = 64,
   parameter int RW   = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [RW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [RW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [ROWS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/cpba_row_unit.sv
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator: row unit
// Works one bitmap byte: first-fit run search, or fill of a page range.
// ----------------------------------------------------------------------------
`default_nettype none

module cpba_row_unit #(
   parameter int XW = 10
) (
   input  wire cpba_pkg::row_ctrl_type ctrl,
   input  wire logic [7:0]    row_data,
   input  wire logic [XW-1:0] base,      // page index of bit 0
   input  wire logic [XW-1:0] limit,     // pages searched
   input  wire logic [XW-1:0] want,      // run length sought, at least 1
   input  wire logic [XW-1:0] run_in,
   input  wire logic [XW-1:0] start_in,
   input  wire logic [XW-1:0] lo,        // fill range, lo inclusive
   input  wire logic [XW-1:0] hi,        // hi exclusive
   output logic      [7:0]    row_out,
   output logic      [XW-1:0] run_out,
   output logic      [XW-1:0] start_out,
   output logic               found
);

   // search: one page per step, stops at the first run long enough
   always_comb begin
      logic [XW-1:0] run;
      logic [XW-1:0] st;
      logic          hit;
      logic [XW-1:0] pidx;
      run = run_in;
      st  = start_in;
      hit = 1'b0;
      for (int j = 0; j < 8; j++) begin
         pidx = base + XW'(j);
         if (ctrl.scan_en && !hit && (pidx < limit)) begin
            if (!row_data[j]) begin
               if (run == '0) begin
                  st = pidx;
               end
               run = run + XW'(1);
               if (run >= want) begin
                  hit = 1'b1;
               end
            end else begin
               run = '0;
            end
         end
      end
      run_out   = run;
      start_out = st;
      found     = hit;
   end

   // fill: bits inside [lo, hi) take the fill value
   always_comb begin
      logic [XW-1:0] pidx;
      for (int j = 0; j < 8; j++) begin
         pidx = base + XW'(j);
         if ((pidx >= lo) && (pidx < hi)) begin
            row_out[j] = ctrl.fill_value;
         end else begin
            row_out[j] = row_data[j];
         end
      end
   end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator: self-checking testbench
// Sends allocate and free requests through the request channel and keeps a
// shadow page map in step with every accepted beat. Each result beat is
// checked field by field against the oldest predicted result. Page size and
// searched range are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int PAGES       = cpba_pkg::MAP_PAGES_DEFAULT;
   localparam int MODE_W      = cpba_pkg::MODE_W;
   localparam int LEN_W       = cpba_pkg::LEN_W;
   localparam int ADDR_W      = cpba_pkg::ADDR_W;
   localparam int STATUS_W    = cpba_pkg::STATUS_W;
   localparam int START_W     = cpba_pkg::START_W;
   localparam int COUNT_W     = cpba_pkg::COUNT_W;
   localparam int LG_W        = cpba_pkg::LG_W;
   localparam int MAP_BYTES_W = cpba_pkg::MAP_BYTES_W;
   localparam int CSR_INDEX_W = cpba_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = cpba_pkg::CSR_DATA_W;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [LEN_W-1:0]  length_bytes;
      logic [ADDR_W-1:0] address;
   } map_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  first_page;
      logic [ADDR_W-1:0]   virt_address;
      logic [COUNT_W-1:0]  page_count;
   } map_rsp_type;

   // clock and reset
   logic clock;
   logic reset = 1'b1;

   // DUT inputs, all known from time zero
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic [MODE_W-1:0]      req_mode = '0;
   logic [LEN_W-1:0]       req_length_bytes = '0;
   logic [ADDR_W-1:0]      req_address = '0;
   logic                   rsp_stall = 1'b0;

   // DUT outputs
   logic                req_stall;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [START_W-1:0]  rsp_first_page;
   logic [ADDR_W-1:0]   rsp_virt_address;
   logic [COUNT_W-1:0]  rsp_page_count;

   // shadow state: page map and the two registers
   logic [PAGES-1:0]  used_map = '0;
   logic [LG_W-1:0]        cfg_lg = cpba_pkg::PAGE_SIZE_LOG2_RESET;
   logic [MAP_BYTES_W-1:0] cfg_map_bytes = cpba_pkg::MAP_BYTES_IN_USE_RESET;

   map_req_type pending_reqs[$];
   map_rsp_type expected_rsps[$];

   // idling control
   logic no_idle = 1'b0;     // phase with no gaps and no stalls
   logic hold_go = 1'b0;     // kicks off a long receiver hold-off
   int   hold_cycles = 0;
   int   gap_left = 0;
   int   stall_left = 0;

   // bookkeeping
   int n_errors = 0;
   int n_alloc = 0;
   int n_free = 0;
   int n_checked = 0;
   int n_csr_writes = 0;

   contiguous_page_bitmap_allocator #(
      .MAP_PAGES(PAGES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_length_bytes (req_length_bytes),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_first_page   (rsp_first_page),
      .rsp_virt_address (rsp_virt_address),
      .rsp_page_count   (rsp_page_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shadow allocator: works out the result of one request and updates the
   // page map. All shifts are 64 bits wide so every page size is safe.
   function automatic map_rsp_type predict_map_op(input map_req_type rq);
      map_rsp_type rsp;
      logic [63:0] unit, count, lim, run, first, idx, last, i, va;
      logic        found;
      unit       = 64'd1 << cfg_lg;
      count      = (64'(rq.length_bytes) + unit - 64'd1) >> cfg_lg;
      first      = '0;
      found      = 1'b0;
      rsp.status = cpba_pkg::STATUS_OK;
      if (rq.mode == cpba_pkg::MODE_ALLOC) begin
         lim = 64'(cfg_map_bytes) * 64'd8;
         if (lim > PAGES) lim = PAGES;
         run = '0;
         // first fit: lowest run of count clear bits; a zero count
         // stops at the first clear bit and marks nothing
         for (i = 0; i < lim && !found; i++) begin
            if (!used_map[i]) begin
               if (run == 0) first = i;
               run++;
               found = (run >= count);
            end else begin
               run = '0;
            end
         end
         if (found) begin
            for (i = first; i < first + count && i < PAGES; i++) used_map[i] = 1'b1;
         end else begin
            rsp.status = cpba_pkg::STATUS_NO_SPACE;
            first      = '0;
         end
      end else begin
         idx = 64'(rq.address) >> cfg_lg;
         if (idx >= PAGES) begin
            rsp.status = cpba_pkg::STATUS_OUT_OF_MAP;
         end else begin
            // pages past the end of the map are dropped
            last = idx + count;
            if (last > PAGES) last = PAGES;
            for (i = idx; i < last; i++) used_map[i] = 1'b0;
            first = idx;
         end
      end
      va               = first << cfg_lg;
      rsp.first_page   = first[START_W-1:0];
      rsp.virt_address = va[ADDR_W-1:0];
      rsp.page_count   = count[COUNT_W-1:0];
      return rsp;
   endfunction

   // Mostly well-formed traffic for the current settings: small runs, frees
   // aimed inside the searched range, a few wipes of the whole map and some
   // raw noise so every input bit toggles.
   function automatic map_req_type random_map_req();
      map_req_type rq;
      int          r, pages, span;
      logic [63:0] unit, ofs, rnd, len64, idx, addr64;
      r     = $urandom_range(0, 99);
      unit  = 64'd1 << cfg_lg;
      ofs   = {$urandom, $urandom} & (unit - 64'd1);
      rnd   = {$urandom, $urandom};
      span  = (int'(cfg_map_bytes) * 8 > PAGES) ? PAGES : int'(cfg_map_bytes) * 8;
      if (span == 0) span = 8;
      rq.mode         = cpba_pkg::MODE_ALLOC;
      rq.length_bytes = '0;
      rq.address      = rnd[ADDR_W-1:0];   // don't-care on allocate
      if (r < 8) begin
         rq.mode         = ($urandom_range(0, 1) == 1) ? cpba_pkg::MODE_FREE
                                                       : cpba_pkg::MODE_ALLOC;
         rq.length_bytes = $urandom;
      end else if (r < 12) begin
         rq.length_bytes = '0;             // zero-length allocate
      end else if (r < 15) begin
         rq.mode         = cpba_pkg::MODE_FREE;      // wipe the whole map
         rq.address      = ofs[ADDR_W-1:0];
         rq.length_bytes = '1;
      end else begin
         pages = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
         len64 = 64'(pages - 1) * unit + ofs + 64'd1;
         if (len64 > 64'hFFFF_FFFF) len64 = 64'hFFFF_FFFF;
         rq.length_bytes = len64[LEN_W-1:0];
         if (r >= 58) begin
            rq.mode    = cpba_pkg::MODE_FREE;
            idx        = (r >= 96) ? 64'($urandom_range(0, PAGES + 88))
                                   : 64'($urandom_range(0, span - 1));
            addr64     = (idx << cfg_lg) | (rnd & (unit - 64'd1));
            rq.address = addr64[ADDR_W-1:0];
         end
      end
      return rq;
   endfunction

   // idle length for either side: mostly none, some short, a few long
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         n_errors++;
      end
   endtask

   task automatic push_req(input logic [MODE_W-1:0] m, input logic [LEN_W-1:0] len,
                           input logic [ADDR_W-1:0] addr);
      map_req_type rq;
      rq.mode         = m;
      rq.length_bytes = len;
      rq.address      = addr;
      pending_reqs.push_back(rq);
   endtask

   // only called while idle, so the shadow copy can follow at once
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == cpba_pkg::CSR_PAGE_SIZE_LOG2) cfg_lg = val[LG_W-1:0];
      else                                     cfg_map_bytes = val[MAP_BYTES_W-1:0];
      n_csr_writes++;
   endtask

   // every request yields one result, so empty queues mean idle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // Driver: retire the accepted beat into the shadow model, then either
   // count down a gap or present the next pending request. req_valid gets
   // exactly one assignment per edge.
   always @(posedge clock) begin : driver
      logic        next_valid;
      map_req_type rq;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            rq.mode         = req_mode;
            rq.length_bytes = req_length_bytes;
            rq.address      = req_address;
            expected_rsps.push_back(predict_map_op(rq));
            if (req_mode == cpba_pkg::MODE_ALLOC) n_alloc++;
            else                                  n_free++;
            next_valid = 1'b0;
            gap_left   = pick_idle_len();
         end
         if (!next_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_reqs.size() != 0) begin
               rq = pending_reqs.pop_front();
               req_mode         <= rq.mode;
               req_length_bytes <= rq.length_bytes;
               req_address      <= rq.address;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Long receiver hold-off, counted here; the monitor just reads it.
   always @(posedge clock) begin : hold_off
      if (hold_go)                hold_cycles <= 400;
      else if (hold_cycles != 0)  hold_cycles <= hold_cycles - 1;
   end

   // Monitor: check each accepted result beat against the oldest prediction
   always @(posedge clock) begin : monitor
      map_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("result beat with no request outstanding");
               n_errors++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("first_page", 64'(want.first_page), 64'(rsp_first_page));
               check_field("virt_address", 64'(want.virt_address), 64'(rsp_virt_address));
               check_field("page_count", 64'(want.page_count), 64'(rsp_page_count));
               n_checked++;
            end
         end
         if (stall_left != 0) stall_left--;
         else                 stall_left = pick_idle_len();
         rsp_stall <= (hold_cycles != 0) || (stall_left != 0);
      end
   end

   // Stimulus sequence
   initial begin : sequencer
      logic [CSR_DATA_W-1:0] lg_val, mb_val;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset settings: 512 pages of 2 MiB
      push_req(cpba_pkg::MODE_ALLOC, 32'd0, '0);          // zero length on empty map
      push_req(cpba_pkg::MODE_ALLOC, 32'd1, '0);          // one byte -> one page
      push_req(cpba_pkg::MODE_ALLOC, 32'h0020_0000, '1);  // exactly one page
      push_req(cpba_pkg::MODE_ALLOC, 32'h0020_0001, '0);  // just over -> two pages
      push_req(cpba_pkg::MODE_ALLOC, 32'hFFFF_FFFF, '0);  // larger than map: no space
      push_req(cpba_pkg::MODE_FREE, 32'd1, '0);           // release page 0
      push_req(cpba_pkg::MODE_ALLOC, 32'd0, '0);          // first free is page 0 again
      push_req(cpba_pkg::MODE_FREE, 32'd1, '1);           // start beyond the map
      // run past the end
      push_req(cpba_pkg::MODE_FREE, 32'hFFFF_FFFF, (39'd511 << 21) + 39'd5);
      push_req(cpba_pkg::MODE_FREE, 32'hFFFF_FFFF, '0);   // wipe
      push_req(cpba_pkg::MODE_ALLOC, 32'h4000_0000, '0);  // whole map
      push_req(cpba_pkg::MODE_ALLOC, 32'd0, '0);          // map full, zero length
      push_req(cpba_pkg::MODE_ALLOC, 32'd1, '0);          // map full
      push_req(cpba_pkg::MODE_FREE, 32'h0060_0000, 39'd100 << 21);  // hole of three pages
      push_req(cpba_pkg::MODE_ALLOC, 32'h0040_0000, '0);  // fits at 100
      push_req(cpba_pkg::MODE_ALLOC, 32'h0040_0000, '0);  // one page left: no space
      push_req(cpba_pkg::MODE_ALLOC, 32'd1, '0);          // takes page 102
      push_req(cpba_pkg::MODE_FREE, 32'hFFFF_FFFF, '0);
      wait_drained();

      // byte-sized pages, only eight pages searched
      write_csr(cpba_pkg::CSR_PAGE_SIZE_LOG2, 7'd0);
      write_csr(cpba_pkg::CSR_MAP_BYTES_IN_USE, 7'd1);
      @(negedge clock);
      push_req(cpba_pkg::MODE_ALLOC, 32'hFFFF_FFFF, '0);  // count wider than the field
      push_req(cpba_pkg::MODE_ALLOC, 32'd8, '0);          // fills the searched range
      push_req(cpba_pkg::MODE_ALLOC, 32'd0, '0);          // nothing free in range
      push_req(cpba_pkg::MODE_FREE, 32'd2, 39'd3);
      wait_drained();

      // largest page size, empty search range
      write_csr(cpba_pkg::CSR_PAGE_SIZE_LOG2, 7'd31);
      write_csr(cpba_pkg::CSR_MAP_BYTES_IN_USE, 7'd0);
      @(negedge clock);
      push_req(cpba_pkg::MODE_ALLOC, 32'd0, '0);
      push_req(cpba_pkg::MODE_FREE, 32'd1, '1);           // top address bits give page 255
      push_req(cpba_pkg::MODE_ALLOC, 32'd1, '0);
      wait_drained();

      // Random phases
      for (int ph = 0; ph < 8; ph++) begin
         unique case (ph)
            0: begin lg_val = 7'h75; mb_val = 7'd64;  end   // upper bits dropped -> 21
            1: begin lg_val = 7'd12; mb_val = 7'd64;  end
            2: begin lg_val = 7'd30; mb_val = 7'd127; end
            3: begin lg_val = 7'd31; mb_val = 7'd1;   end
            4: begin lg_val = 7'd0;  mb_val = 7'd8;   end
            default: begin
               lg_val = 7'($urandom_range(12, 30));
               mb_val = 7'($urandom_range(1, 64));
            end
         endcase
         write_csr(cpba_pkg::CSR_PAGE_SIZE_LOG2, lg_val);
         write_csr(cpba_pkg::CSR_MAP_BYTES_IN_USE, mb_val);
         no_idle <= (ph == 6);
         @(negedge clock);
         for (int n = 0; n < 88; n++) pending_reqs.push_back(random_map_req());
         // receiver holds off while the sender keeps offering beats
         if (ph == 2 || ph == 5) begin
            @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         wait_drained();
      end

      repeat (150) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d results never arrived", expected_rsps.size());
         n_errors++;
      end
      $display("Covered %0d allocate and %0d free requests across %0d register writes,",
               n_alloc, n_free, n_csr_writes);
      $display("with %0d result beats compared against the shadow page map.", n_checked);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
+incdir+sv
sv/cpba_pkg.sv
sv/cpba_map_mem.sv
sv/cpba_row_unit.sv
sv/contiguous_page_bitmap_allocator.sv
dv/tb_top.sv
